// ===== rtl/sbbc_pkg.sv =====
// Package: payload types and constants for the shaft build and box cull block
`timescale 1ns / 1ps
`default_nettype none
package sbbc_pkg;
  localparam int MAX_VERTS  = 4;
  localparam int MAX_PLANES = 34;
  localparam int NSTORE     = 2 * MAX_VERTS;
  localparam int VIDX_W     = $clog2(NSTORE);
  localparam int CNT_W      = $clog2(MAX_VERTS + 1);
  localparam int PIDX_W     = $clog2(MAX_PLANES);
  localparam int PCNT_W     = 6;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_TEST   = 2'd2;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_BUILT  = 2'd1;
  localparam logic [1:0] KIND_TESTED = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic               last_vertex;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] x_low;
    logic signed [31:0] x_high;
    logic signed [31:0] y_low;
    logic signed [31:0] y_high;
    logic signed [31:0] z_low;
    logic signed [31:0] z_high;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic              in_shaft;
    logic [PCNT_W-1:0] plane_count;
  } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/sbbc_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read
`timescale 1ns / 1ps
`default_nettype none
module sbbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 34
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/shaft_build_and_box_cull_top.sv =====
// Top level: shaft build from two patches and box-against-shaft test
// Vertex load: a result per load. Box test: box check, then per plane a store read,
// multiply-accumulate and compare (one shared 34x33 multiplier, one product per cycle,
// plane store read once per plane). Shaft build: corner pass, then per candidate plane a
// cross product; a full one adds a square root, three divides and a classify pass.
// One item at a time. Synchronous active-high reset clears counts and control state.
`timescale 1ns / 1ps
`default_nettype none
module shaft_build_and_box_cull_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sbbc_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sbbc_pkg::out_item_t     out_data
);
  typedef enum logic [4:0] {
    S_IDLE, S_BOX, S_TOL, S_PSEL, S_DIFF, S_SHR, S_CROSS, S_CSUM, S_NORM,
    S_SQ, S_SQRT, S_DIV, S_DOTV, S_DOTM, S_CLASS, S_STORE,
    S_TBOX, S_TRD, S_TRDW, S_TMUL, S_TCMP, S_OUT
  } state_t;

  state_t state;

  logic signed [31:0] vx [sbbc_pkg::NSTORE];
  logic signed [31:0] vy [sbbc_pkg::NSTORE];
  logic signed [31:0] vz [sbbc_pkg::NSTORE];
  logic [sbbc_pkg::CNT_W-1:0]  count_a, count_b;
  logic signed [31:0] sbox [6];
  logic [31:0]        tolerance;
  logic [sbbc_pkg::PCNT_W-1:0] planes_kept;
  sbbc_pkg::in_item_t item;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // plane store
  logic                         pl_we;
  logic [sbbc_pkg::PIDX_W-1:0]  pl_waddr, pl_raddr;
  logic [143:0]                 pl_wdata, pl_rdata;
  sbbc_ram #(.WIDTH(144), .DEPTH(sbbc_pkg::MAX_PLANES)) u_planes (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(pl_raddr), .rdata(pl_rdata)
  );

  // build working registers
  logic [2:0]  step;
  logic [3:0]  vi;
  logic [5:0]  cand;
  logic [3:0]  ci, ck;
  logic [2:0]  pp, pq, pr;
  logic signed [32:0] u [3];
  logic signed [32:0] v [3];
  logic signed [63:0] c [3];
  logic signed [63:0] prod_a;
  logic [63:0] ss;
  logic [63:0] sq_x, sq_r, sq_bit;
  logic [31:0] len;
  logic [1:0]  k3;
  logic signed [63:0] num;
  logic [63:0] dq, drem;
  logic [6:0]  dcnt;
  logic signed [31:0] n [3];
  logic signed [65:0] acc;
  logic signed [49:0] d_off;
  logic        pos, neg, first_dot;
  logic        pass;
  logic [sbbc_pkg::PCNT_W-1:0] ti;

  logic [3:0] total;
  assign total = 4'(count_a) + 4'(count_b);

  function automatic logic [2:0] vidx(input logic [3:0] i, input logic [3:0] ca);
    if (i < ca) begin
      return 3'(i);
    end
    return 3'(4'(sbbc_pkg::MAX_VERTS) + i - ca);
  endfunction

  function automatic logic signed [63:0] abs64(input logic signed [63:0] a);
    return a[63] ? -a : a;
  endfunction

  function automatic logic signed [32:0] half33(input logic signed [32:0] a);
    return a[32] ? -((-a) >>> 1) : (a >>> 1);
  endfunction

  function automatic logic signed [63:0] half64(input logic signed [63:0] a);
    return a[63] ? -((-a) >>> 1) : (a >>> 1);
  endfunction

  function automatic logic big33(input logic signed [32:0] a);
    logic signed [32:0] m;
    m = a[32] ? -a : a;
    return m > 33'sd2147483647;
  endfunction

  logic [2:0] jv;
  assign jv = vidx(vi, 4'(count_a));

  logic [2:0] jd;
  assign jd = first_dot ? pp : jv;

  logic signed [31:0] bx, by, bz;
  assign bx = n[0] > 0 ? item.x_high : item.x_low;
  assign by = n[1] > 0 ? item.y_high : item.y_low;
  assign bz = n[2] > 0 ? item.z_high : item.z_low;

  logic signed [49:0] dotv;
  assign dotv = 50'(acc >>> 16);

  logic signed [49:0] tol_s;
  assign tol_s = 50'($signed({1'b0, tolerance}) * 50'sd16384);

  logic signed [63:0] cmax;
  assign cmax = (abs64(c[0]) > abs64(c[1])) ?
                ((abs64(c[0]) > abs64(c[2])) ? abs64(c[0]) : abs64(c[2])) :
                ((abs64(c[1]) > abs64(c[2])) ? abs64(c[1]) : abs64(c[2]));

  logic [63:0] drem_sh;
  assign drem_sh = {drem[62:0], dq[63]};

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CROSS: begin
        case (step)
          3'd0: begin mul_a = 34'(u[1]); mul_b = v[2]; end
          3'd1: begin mul_a = 34'(u[2]); mul_b = v[1]; end
          3'd2: begin mul_a = 34'(u[2]); mul_b = v[0]; end
          3'd3: begin mul_a = 34'(u[0]); mul_b = v[2]; end
          3'd4: begin mul_a = 34'(u[0]); mul_b = v[1]; end
          default: begin mul_a = 34'(u[1]); mul_b = v[0]; end
        endcase
      end
      S_SQ: begin
        mul_a = 34'(c[k3][31:0] == 32'h0 && c[k3][63] ? 64'sd0 : c[k3]);
        mul_b = 33'(c[k3]);
      end
      S_DOTV: begin
        case (step)
          3'd0: begin mul_a = 34'(n[0]); mul_b = 33'(vx[jd]); end
          3'd1: begin mul_a = 34'(n[1]); mul_b = 33'(vy[jd]); end
          default: begin mul_a = 34'(n[2]); mul_b = 33'(vz[jd]); end
        endcase
      end
      S_TMUL: begin
        case (step)
          3'd0: begin mul_a = 34'(n[0]); mul_b = 33'(bx); end
          3'd1: begin mul_a = 34'(n[1]); mul_b = 33'(by); end
          default: begin mul_a = 34'(n[2]); mul_b = 33'(bz); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    pl_we    = (state == S_STORE) && (pos != neg);
    pl_waddr = sbbc_pkg::PIDX_W'(planes_kept);
    pl_wdata = neg ? {-n[0], -n[1], -n[2], 48'(-d_off - tol_s)}
                   : {n[0], n[1], n[2], 48'(d_off - tol_s)};
    pl_raddr = sbbc_pkg::PIDX_W'(ti);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      count_a     <= '0;
      count_b     <= '0;
      tolerance   <= '0;
      planes_kept <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            case (in_data.mode)
              sbbc_pkg::MODE_LOAD_A, sbbc_pkg::MODE_LOAD_B: begin
                if (in_data.mode == sbbc_pkg::MODE_LOAD_A &&
                    count_a < sbbc_pkg::CNT_W'(sbbc_pkg::MAX_VERTS)) begin
                  vx[3'(count_a)] <= in_data.coord_x;
                  vy[3'(count_a)] <= in_data.coord_y;
                  vz[3'(count_a)] <= in_data.coord_z;
                  count_a <= count_a + 1'b1;
                end
                if (in_data.mode == sbbc_pkg::MODE_LOAD_B &&
                    count_b < sbbc_pkg::CNT_W'(sbbc_pkg::MAX_VERTS)) begin
                  vx[3'(count_b) + 3'(sbbc_pkg::MAX_VERTS)] <= in_data.coord_x;
                  vy[3'(count_b) + 3'(sbbc_pkg::MAX_VERTS)] <= in_data.coord_y;
                  vz[3'(count_b) + 3'(sbbc_pkg::MAX_VERTS)] <= in_data.coord_z;
                  count_b <= count_b + 1'b1;
                end
                if (in_data.mode == sbbc_pkg::MODE_LOAD_B && in_data.last_vertex) begin
                  vi    <= '0;
                  state <= S_BOX;
                end else begin
                  out_data  <= '{sbbc_pkg::KIND_VERTEX, 1'b0, planes_kept};
                  state     <= S_OUT;
                end
              end
              sbbc_pkg::MODE_TEST: begin
                state <= S_TBOX;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_BOX: begin
          if (vi == total) begin
            state <= S_TOL;
          end else begin
            if (vi == 4'd0 || vx[jv] < sbox[0]) sbox[0] <= vx[jv];
            if (vi == 4'd0 || vx[jv] > sbox[1]) sbox[1] <= vx[jv];
            if (vi == 4'd0 || vy[jv] < sbox[2]) sbox[2] <= vy[jv];
            if (vi == 4'd0 || vy[jv] > sbox[3]) sbox[3] <= vy[jv];
            if (vi == 4'd0 || vz[jv] < sbox[4]) sbox[4] <= vz[jv];
            if (vi == 4'd0 || vz[jv] > sbox[5]) sbox[5] <= vz[jv];
            vi <= vi + 1'b1;
          end
        end
        S_TOL: begin
          begin : tol_blk
            logic signed [32:0] e0, e1, e2, ext;
            e0 = 33'(sbox[1]) - 33'(sbox[0]);
            e1 = 33'(sbox[3]) - 33'(sbox[2]);
            e2 = 33'(sbox[5]) - 33'(sbox[4]);
            ext = e0;
            if (e1 > ext) ext = e1;
            if (e2 > ext) ext = e2;
            if (ext < 0) ext = '0;
            tolerance <= 32'(ext >>> 26) + 32'd1;
          end
          planes_kept <= '0;
          cand <= '0;
          ci <= '0;
          ck <= '0;
          if (count_a < 3'd3 || count_b < 3'd3) begin
            state <= S_OUT;
            out_data <= '{sbbc_pkg::KIND_BUILT, 1'b0, '0};
            count_a <= '0;
            count_b <= '0;
          end else begin
            state <= S_PSEL;
          end
        end
        S_PSEL: begin
          if (planes_kept >= sbbc_pkg::PCNT_W'(sbbc_pkg::MAX_PLANES) ||
              (cand >= 6'd2 && ci == (cand[0] ? 4'(count_b) : 4'(count_a)) &&
               cand[5:1] != 5'd0 && cand != 6'd2 && cand == 6'd3)) begin
            out_data  <= '{sbbc_pkg::KIND_BUILT, 1'b0, planes_kept};
            count_a <= '0;
            count_b <= '0;
            state <= S_OUT;
          end else begin
            if (cand == 6'd0) begin
              pp <= 3'd0; pq <= 3'd1; pr <= 3'd2;
              cand <= 6'd1;
              state <= S_DIFF;
            end else if (cand == 6'd1) begin
              pp <= 3'd4; pq <= 3'd5; pr <= 3'd6;
              cand <= 6'd2;
              state <= S_DIFF;
            end else if (cand == 6'd2) begin
              if (ci == 4'(count_a)) begin
                cand <= 6'd3;
                ci <= '0;
                ck <= '0;
              end else begin
                pp <= 3'(ci);
                pq <= (ci + 1'b1 == 4'(count_a)) ? 3'd0 : 3'(ci + 1'b1);
                pr <= 3'(4'(sbbc_pkg::MAX_VERTS) + ck);
                if (ck + 1'b1 == 4'(count_b)) begin
                  ck <= '0; ci <= ci + 1'b1;
                end else begin
                  ck <= ck + 1'b1;
                end
                state <= S_DIFF;
              end
            end else begin
              if (ci == 4'(count_b)) begin
                out_data  <= '{sbbc_pkg::KIND_BUILT, 1'b0, planes_kept};
                count_a <= '0;
                count_b <= '0;
                state <= S_OUT;
              end else begin
                pp <= 3'(4'(sbbc_pkg::MAX_VERTS) + ci);
                pq <= (ci + 1'b1 == 4'(count_b)) ? 3'(sbbc_pkg::MAX_VERTS)
                      : 3'(4'(sbbc_pkg::MAX_VERTS) + ci + 1'b1);
                pr <= 3'(ck);
                if (ck + 1'b1 == 4'(count_a)) begin
                  ck <= '0; ci <= ci + 1'b1;
                end else begin
                  ck <= ck + 1'b1;
                end
                state <= S_DIFF;
              end
            end
          end
        end
        S_DIFF: begin
          u[0] <= 33'(vx[pq]) - 33'(vx[pp]);
          u[1] <= 33'(vy[pq]) - 33'(vy[pp]);
          u[2] <= 33'(vz[pq]) - 33'(vz[pp]);
          v[0] <= 33'(vx[pr]) - 33'(vx[pp]);
          v[1] <= 33'(vy[pr]) - 33'(vy[pp]);
          v[2] <= 33'(vz[pr]) - 33'(vz[pp]);
          state <= S_SHR;
        end
        S_SHR: begin
          if (big33(u[0]) || big33(u[1]) || big33(u[2])) begin
            u[0] <= half33(u[0]); u[1] <= half33(u[1]); u[2] <= half33(u[2]);
          end
          if (big33(v[0]) || big33(v[1]) || big33(v[2])) begin
            v[0] <= half33(v[0]); v[1] <= half33(v[1]); v[2] <= half33(v[2]);
          end
          if (!(big33(u[0]) || big33(u[1]) || big33(u[2]) ||
                big33(v[0]) || big33(v[1]) || big33(v[2]))) begin
            step <= '0;
            state <= S_CROSS;
          end
        end
        S_CROSS: begin
          if (!step[0]) begin
            prod_a <= 64'(mul_p);
          end else begin
            c[step[2:1]] <= prod_a - 64'(mul_p);
          end
          step <= step + 1'b1;
          if (step == 3'd5) begin
            state <= S_CSUM;
          end
        end
        S_CSUM: begin
          if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            state <= S_PSEL;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (cmax > 64'sd2147483647) begin
            c[0] <= half64(c[0]); c[1] <= half64(c[1]); c[2] <= half64(c[2]);
          end else if (cmax < 64'sd1073741824) begin
            c[0] <= c[0] <<< 1; c[1] <= c[1] <<< 1; c[2] <= c[2] <<< 1;
          end else begin
            k3 <= '0;
            ss <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          ss <= ss + 64'(mul_p);
          k3 <= k3 + 1'b1;
          if (k3 == 2'd2) begin
            sq_x   <= ss + 64'(mul_p);
            sq_r   <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_bit == 0) begin
            len   <= 32'(sq_r);
            k3    <= '0;
            num   <= c[0] <<< 30;
            dq    <= 64'(abs64(c[0] <<< 30));
            drem  <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end else if (sq_x >= sq_r + sq_bit) begin
            sq_x <= sq_x - (sq_r + sq_bit);
            sq_r <= (sq_r >> 1) + sq_bit;
            sq_bit <= sq_bit >> 2;
          end else begin
            sq_r <= sq_r >> 1;
            sq_bit <= sq_bit >> 2;
          end
        end
        S_DIV: begin
          if (dcnt == 7'd64) begin
            n[k3] <= 32'(num[63] ? -$signed(dq) : $signed(dq));
            if (k3 == 2'd2) begin
              vi <= '0;
              step <= '0;
              acc <= '0;
              first_dot <= 1'b1;
              pos <= 1'b0;
              neg <= 1'b0;
              state <= S_DOTV;
            end else begin
              k3   <= k3 + 1'b1;
              num  <= c[k3 + 1'b1] <<< 30;
              dq   <= 64'(abs64(c[k3 + 1'b1] <<< 30));
              drem <= '0;
              dcnt <= '0;
            end
          end else begin
            if (drem_sh >= 64'(len)) begin
              drem <= drem_sh - 64'(len);
              dq   <= {dq[62:0], 1'b1};
            end else begin
              drem <= drem_sh;
              dq   <= {dq[62:0], 1'b0};
            end
            dcnt <= dcnt + 1'b1;
          end
        end
        S_DOTV: begin
          acc  <= acc + 66'(mul_p);
          step <= step + 1'b1;
          if (step == 3'd2) begin
            state <= S_DOTM;
          end
        end
        S_DOTM: begin
          acc  <= '0;
          step <= '0;
          if (first_dot) begin
            d_off <= dotv;
            first_dot <= 1'b0;
            vi <= '0;
            state <= S_DOTV;
          end else begin
            if (dotv - d_off > tol_s) pos <= 1'b1;
            if (dotv - d_off < -tol_s) neg <= 1'b1;
            if (vi + 1'b1 == total) begin
              state <= S_STORE;
            end else begin
              vi <= vi + 1'b1;
              state <= S_DOTV;
            end
          end
        end
        S_CLASS: begin
          state <= S_STORE;
        end
        S_STORE: begin
          if (pos != neg) begin
            planes_kept <= planes_kept + 1'b1;
          end
          state <= S_PSEL;
        end
        S_TBOX: begin
          if (item.x_high < sbox[0] || item.x_low > sbox[1] ||
              item.y_high < sbox[2] || item.y_low > sbox[3] ||
              item.z_high < sbox[4] || item.z_low > sbox[5]) begin
            pass <= 1'b0;
            ti   <= planes_kept;
          end else begin
            pass <= 1'b1;
            ti   <= '0;
          end
          state <= S_TRD;
        end
        S_TRD: begin
          if (ti >= planes_kept || !pass) begin
            out_data <= '{sbbc_pkg::KIND_TESTED, pass, planes_kept};
            state <= S_OUT;
          end else begin
            state <= S_TRDW;
          end
        end
        S_TRDW: begin
          n[0]  <= pl_rdata[143:112];
          n[1]  <= pl_rdata[111:80];
          n[2]  <= pl_rdata[79:48];
          d_off <= 50'($signed(pl_rdata[47:0]));
          acc   <= '0;
          step  <= '0;
          state <= S_TMUL;
        end
        S_TMUL: begin
          acc  <= acc + 66'(mul_p);
          step <= step + 1'b1;
          if (step == 3'd2) begin
            state <= S_TCMP;
          end
        end
        S_TCMP: begin
          if (dotv < d_off) begin
            pass <= 1'b0;
          end
          ti <= ti + 1'b1;
          state <= S_TRD;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("ready outside idle");
  a_planes_max: assert property (@(posedge clk) disable iff (rst)
    planes_kept <= sbbc_pkg::PCNT_W'(sbbc_pkg::MAX_PLANES))
    else $error("plane count overflow");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result without sequencer");
  a_counts: assert property (@(posedge clk) disable iff (rst)
    count_a <= 3'd4 && count_b <= 3'd4)
    else $error("vertex count overflow");
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench: directed and random transactions checked against a shaft culling predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int RANDOM_ITEMS   = 1950;
  localparam longint LIM31 = 64'sd2147483647;
  localparam longint TWO30 = 64'sd1073741824;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sbbc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sbbc_pkg::out_item_t out_data;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  shaft_build_and_box_cull_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // shadow state
  longint vx[sbbc_pkg::NSTORE], vy[sbbc_pkg::NSTORE], vz[sbbc_pkg::NSTORE];
  int unsigned na, nb;
  longint sbox[6];
  longint tol;
  longint nxs[sbbc_pkg::MAX_PLANES], nys[sbbc_pkg::MAX_PLANES];
  longint nzs[sbbc_pkg::MAX_PLANES], offs[sbbc_pkg::MAX_PLANES];
  int unsigned nplanes;
  bit built;

  sbbc_pkg::out_item_t expected_q[$];
  int mismatches = 0;
  int watchdog = 0;

  function automatic longint fshift16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint plane_dot(longint a, longint b, longint c,
                                       longint x, longint y, longint z);
    return fshift16(a * x + b * y + c * z);
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic int unsigned slot(int unsigned i);
    return (i < na) ? i : (sbbc_pkg::MAX_VERTS + (i - na));
  endfunction

  task automatic try_hull_plane(int unsigned p, int unsigned q, int unsigned r);
    longint u[3], v[3], c[3], n[3], d, tols, len, t, m;
    int unsigned pos, neg;
    longint unsigned ss;
    pos = 0;
    neg = 0;
    if (nplanes >= sbbc_pkg::MAX_PLANES) return;
    u[0] = vx[q] - vx[p]; u[1] = vy[q] - vy[p]; u[2] = vz[q] - vz[p];
    v[0] = vx[r] - vx[p]; v[1] = vy[r] - vy[p]; v[2] = vz[r] - vz[p];
    while (labs(u[0]) > LIM31 || labs(u[1]) > LIM31 || labs(u[2]) > LIM31)
      for (int k = 0; k < 3; k++) u[k] = u[k] / 2;
    while (labs(v[0]) > LIM31 || labs(v[1]) > LIM31 || labs(v[2]) > LIM31)
      for (int k = 0; k < 3; k++) v[k] = v[k] / 2;
    c[0] = u[1] * v[2] - u[2] * v[1];
    c[1] = u[2] * v[0] - u[0] * v[2];
    c[2] = u[0] * v[1] - u[1] * v[0];
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) return;
    m = labs(c[0]);
    if (labs(c[1]) > m) m = labs(c[1]);
    if (labs(c[2]) > m) m = labs(c[2]);
    while (m > LIM31) begin
      for (int k = 0; k < 3; k++) c[k] = c[k] / 2;
      m = m / 2;
    end
    while (m < TWO30) begin
      for (int k = 0; k < 3; k++) c[k] = c[k] * 2;
      m = m * 2;
    end
    ss = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
    len = isqrt(ss);
    for (int k = 0; k < 3; k++) n[k] = (c[k] * TWO30) / len;
    d = plane_dot(n[0], n[1], n[2], vx[p], vy[p], vz[p]);
    tols = tol * 16384;
    for (int unsigned i = 0; i < na + nb; i++) begin
      int unsigned j;
      j = slot(i);
      t = plane_dot(n[0], n[1], n[2], vx[j], vy[j], vz[j]) - d;
      if (t > tols) pos++;
      if (t < -tols) neg++;
    end
    if ((pos != 0) == (neg != 0)) return;
    if (neg != 0) begin
      for (int k = 0; k < 3; k++) n[k] = -n[k];
      d = -d;
    end
    nxs[nplanes] = n[0];
    nys[nplanes] = n[1];
    nzs[nplanes] = n[2];
    offs[nplanes] = d - tols;
    nplanes++;
  endtask

  task automatic build_hull();
    longint ext;
    for (int unsigned i = 0; i < na + nb; i++) begin
      int unsigned j;
      j = slot(i);
      if (i == 0) begin
        sbox[0] = vx[j]; sbox[1] = vx[j];
        sbox[2] = vy[j]; sbox[3] = vy[j];
        sbox[4] = vz[j]; sbox[5] = vz[j];
      end else begin
        if (vx[j] < sbox[0]) sbox[0] = vx[j];
        if (vx[j] > sbox[1]) sbox[1] = vx[j];
        if (vy[j] < sbox[2]) sbox[2] = vy[j];
        if (vy[j] > sbox[3]) sbox[3] = vy[j];
        if (vz[j] < sbox[4]) sbox[4] = vz[j];
        if (vz[j] > sbox[5]) sbox[5] = vz[j];
      end
    end
    ext = sbox[1] - sbox[0];
    if (sbox[3] - sbox[2] > ext) ext = sbox[3] - sbox[2];
    if (sbox[5] - sbox[4] > ext) ext = sbox[5] - sbox[4];
    if (ext < 0) ext = 0;
    tol = (ext >>> 26) + 1;
    nplanes = 0;
    if (na < 3 || nb < 3) return;
    try_hull_plane(0, 1, 2);
    try_hull_plane(sbbc_pkg::MAX_VERTS, sbbc_pkg::MAX_VERTS + 1, sbbc_pkg::MAX_VERTS + 2);
    for (int unsigned i = 0; i < na; i++)
      for (int unsigned k = 0; k < nb; k++)
        try_hull_plane(i, (i + 1) % na, sbbc_pkg::MAX_VERTS + k);
    for (int unsigned i = 0; i < nb; i++)
      for (int unsigned k = 0; k < na; k++)
        try_hull_plane(sbbc_pkg::MAX_VERTS + i, sbbc_pkg::MAX_VERTS + (i + 1) % nb, k);
  endtask

  function automatic bit box_in_shaft(sbbc_pkg::in_item_t it);
    longint xl, xh, yl, yh, zl, zh;
    xl = it.x_low; xh = it.x_high;
    yl = it.y_low; yh = it.y_high;
    zl = it.z_low; zh = it.z_high;
    if (xh < sbox[0] || xl > sbox[1] || yh < sbox[2] || yl > sbox[3] ||
        zh < sbox[4] || zl > sbox[5]) return 0;
    for (int unsigned i = 0; i < nplanes; i++)
      if (plane_dot(nxs[i], nys[i], nzs[i], nxs[i] > 0 ? xh : xl,
                    nys[i] > 0 ? yh : yl, nzs[i] > 0 ? zh : zl) < offs[i])
        return 0;
    return 1;
  endfunction

  // predict the result of one accepted transaction
  task automatic predict_culling(sbbc_pkg::in_item_t it);
    sbbc_pkg::out_item_t r;
    r = '0;
    if (it.mode == 2'd3) return;
    if (it.mode == sbbc_pkg::MODE_LOAD_A || it.mode == sbbc_pkg::MODE_LOAD_B) begin
      if (it.mode == sbbc_pkg::MODE_LOAD_A && na < sbbc_pkg::MAX_VERTS) begin
        vx[na] = it.coord_x; vy[na] = it.coord_y; vz[na] = it.coord_z;
        na++;
      end else if (it.mode == sbbc_pkg::MODE_LOAD_B && nb < sbbc_pkg::MAX_VERTS) begin
        vx[sbbc_pkg::MAX_VERTS + nb] = it.coord_x;
        vy[sbbc_pkg::MAX_VERTS + nb] = it.coord_y;
        vz[sbbc_pkg::MAX_VERTS + nb] = it.coord_z;
        nb++;
      end
      r.result_kind = sbbc_pkg::KIND_VERTEX;
      if (it.mode == sbbc_pkg::MODE_LOAD_B && it.last_vertex) begin
        build_hull();
        na = 0;
        nb = 0;
        built = 1;
        r.result_kind = sbbc_pkg::KIND_BUILT;
      end
    end else begin
      r.result_kind = sbbc_pkg::KIND_TESTED;
      r.in_shaft = box_in_shaft(it);
    end
    r.plane_count = nplanes[sbbc_pkg::PCNT_W-1:0];
    expected_q.push_back(r);
  endtask

  // receiver: stall pattern and compare
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase[7:6] == 2'b00) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %p", out_data);
        end else begin
          sbbc_pkg::out_item_t e;
          e = expected_q.pop_front();
          if (e.result_kind !== out_data.result_kind || e.in_shaft !== out_data.in_shaft ||
              e.plane_count !== out_data.plane_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected kind %0d in %0d planes %0d, got %0d %0d %0d",
                       e.result_kind, e.in_shaft, e.plane_count, out_data.result_kind,
                       out_data.in_shaft, out_data.plane_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send(sbbc_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_culling(it);
  endtask

  function automatic logic [31:0] rand_coord(int span);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic sbbc_pkg::in_item_t vertex_item(logic [1:0] md, logic lastv, int span);
    sbbc_pkg::in_item_t it;
    it = '0;
    it.mode = md;
    it.last_vertex = lastv;
    it.coord_x = rand_coord(span);
    it.coord_y = rand_coord(span);
    it.coord_z = rand_coord(span);
    return it;
  endfunction

  function automatic sbbc_pkg::in_item_t box_item(int span);
    sbbc_pkg::in_item_t it;
    logic signed [31:0] a, b;
    it = vertex_item(sbbc_pkg::MODE_TEST, $urandom_range(0, 1), span);
    for (int k = 0; k < 3; k++) begin
      a = rand_coord(span);
      b = $urandom_range(0, 7) == 0 ? rand_coord(span) : a + $urandom_range(0, span);
      case (k)
        0: begin it.x_low = a; it.x_high = b; end
        1: begin it.y_low = a; it.y_high = b; end
        default: begin it.z_low = a; it.z_high = b; end
      endcase
    end
    return it;
  endfunction

  typedef struct {
    sbbc_pkg::in_item_t   stim;
    bit                   check;
    sbbc_pkg::out_item_t  result;
  } directed_row_t;

  directed_row_t directed[$];

  function automatic sbbc_pkg::in_item_t vtx(logic [1:0] md, logic lastv,
                                             logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
    sbbc_pkg::in_item_t it;
    it = '0;
    it.mode = md;
    it.last_vertex = lastv;
    it.coord_x = x; it.coord_y = y; it.coord_z = z;
    return it;
  endfunction

  function automatic sbbc_pkg::out_item_t res(logic [1:0] k, logic s, int p);
    sbbc_pkg::out_item_t r;
    r.result_kind = k;
    r.in_shaft = s;
    r.plane_count = p[sbbc_pkg::PCNT_W-1:0];
    return r;
  endfunction

  task automatic add_row(sbbc_pkg::in_item_t it, bit chk, sbbc_pkg::out_item_t r);
    directed_row_t row;
    row.stim = it;
    row.check = chk;
    row.result = r;
    directed.push_back(row);
  endtask

  initial begin
    sbbc_pkg::in_item_t it;
    int sent, span;
    bit drained;
    na = 0; nb = 0; nplanes = 0; tol = 0; built = 0;
    drained = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // short patches: A with two corners and a last mark, B with one
    add_row(vtx(sbbc_pkg::MODE_LOAD_A, 1, 32'h0, 32'h0, 32'h0), 1,
            res(sbbc_pkg::KIND_VERTEX, 0, 0));
    add_row(vtx(sbbc_pkg::MODE_LOAD_A, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff), 1,
            res(sbbc_pkg::KIND_VERTEX, 0, 0));
    add_row(vtx(sbbc_pkg::MODE_LOAD_B, 1, 32'h80000000, 32'h7fffffff, 32'h80000000), 1,
            res(sbbc_pkg::KIND_BUILT, 0, 0));
    it = '1;
    it.mode = 2'd3;
    add_row(it, 0, res(sbbc_pkg::KIND_VERTEX, 0, 0));
    it = '0;
    it.mode = sbbc_pkg::MODE_TEST;
    it.x_high = 32'h7fffffff; it.y_high = 32'h7fffffff; it.z_high = 32'h7fffffff;
    it.x_low = 32'h80000000; it.y_low = 32'h80000000; it.z_low = 32'h80000000;
    add_row(it, 1, res(sbbc_pkg::KIND_TESTED, 1, 0));
    // two unit squares one apart, extra corners dropped
    add_row(vtx(sbbc_pkg::MODE_LOAD_A, 0, 32'h0, 32'h0, 32'h0), 0, '0);
    add_row(vtx(sbbc_pkg::MODE_LOAD_A, 0, 32'h10000, 32'h0, 32'h0), 0, '0);
    add_row(vtx(sbbc_pkg::MODE_LOAD_A, 0, 32'h10000, 32'h10000, 32'h0), 0, '0);
    add_row(vtx(sbbc_pkg::MODE_LOAD_A, 0, 32'h0, 32'h10000, 32'h0), 0, '0);
    add_row(vtx(sbbc_pkg::MODE_LOAD_A, 0, 32'h55555, 32'h0, 32'h0), 0, '0);
    add_row(vtx(sbbc_pkg::MODE_LOAD_B, 0, 32'h0, 32'h0, 32'h10000), 0, '0);
    add_row(vtx(sbbc_pkg::MODE_LOAD_B, 0, 32'h10000, 32'h0, 32'h10000), 0, '0);
    add_row(vtx(sbbc_pkg::MODE_LOAD_B, 0, 32'h10000, 32'h10000, 32'h10000), 0, '0);
    add_row(vtx(sbbc_pkg::MODE_LOAD_B, 0, 32'h0, 32'h10000, 32'h10000), 0, '0);
    add_row(vtx(sbbc_pkg::MODE_LOAD_B, 1, 32'h33333, 32'h0, 32'h10000), 0, '0);
    it = '0;
    it.mode = sbbc_pkg::MODE_TEST;
    it.x_low = 32'h8000; it.x_high = 32'h9000;
    it.y_low = 32'h8000; it.y_high = 32'h9000;
    it.z_low = 32'h8000; it.z_high = 32'h9000;
    add_row(it, 0, '0);
    it.x_low = 32'h20000; it.x_high = 32'h30000;
    add_row(it, 0, '0);
    it.x_low = 32'h9000; it.x_high = 32'h8000;
    add_row(it, 0, '0);
    // collinear and duplicate corners: degenerate planes
    for (int k = 0; k < 3; k++)
      add_row(vtx(sbbc_pkg::MODE_LOAD_A, 0, k << 16, k << 16, 0), 0, '0);
    for (int k = 0; k < 2; k++)
      add_row(vtx(sbbc_pkg::MODE_LOAD_B, 0, 32'h10000, 0, 0), 0, '0);
    add_row(vtx(sbbc_pkg::MODE_LOAD_B, 1, 32'h10000, 0, 0), 0, '0);

    foreach (directed[i]) begin
      send(directed[i].stim);
      if (directed[i].check && directed[i].stim.mode != 2'd3) begin
        sbbc_pkg::out_item_t e;
        e = expected_q[expected_q.size() - 1];
        if (e !== directed[i].result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: table %p, predicted %p", i, directed[i].result, e);
        end
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      int unsigned ca, cb;
      span = $urandom_range(0, 3) == 0 ? 32'h7fffffff : (1 << $urandom_range(8, 24));
      if ($urandom_range(0, 9) == 0) begin
        // noise: stray loads, ignored mode, early last marks
        it = vertex_item($urandom_range(0, 3), $urandom_range(0, 1), span);
        if (it.mode == sbbc_pkg::MODE_TEST && !built) it.mode = sbbc_pkg::MODE_LOAD_A;
        send(it);
        sent++;
        continue;
      end
      ca = $urandom_range(3, 5);
      cb = $urandom_range(3, 5);
      if ($urandom_range(0, 7) == 0) ca = $urandom_range(0, 2);
      for (int unsigned k = 0; k < ca; k++)
        send(vertex_item(sbbc_pkg::MODE_LOAD_A, 0, span));
      for (int unsigned k = 0; k < cb; k++)
        send(vertex_item(sbbc_pkg::MODE_LOAD_B, k == cb - 1, span));
      sent += ca + cb;
      repeat ($urandom_range(2, 10)) begin
        send(box_item(span));
        sent++;
      end
      if (!drained && sent > RANDOM_ITEMS / 2) begin
        drained = 1;
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
